@@ rtl/core/ple_pkg.sv @@
// Package for the positional list engine: sizes, operation and status codes,
// and the control word broadcast to the storage cells. No dependencies.
package ple_pkg;

    localparam int DEPTH    = 32;
    localparam int READ_MAX = 32;
    localparam int DATA_W   = 32;
    localparam int FUNC_W   = 3;
    localparam int POS_W    = 6;
    localparam int IDX_W    = $clog2(DEPTH);
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int WIDE_W   = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    localparam logic [FUNC_W-1:0] FN_INS_FRONT = 3'd0;
    localparam logic [FUNC_W-1:0] FN_INS_BACK  = 3'd1;
    localparam logic [FUNC_W-1:0] FN_INS_POS   = 3'd2;
    localparam logic [FUNC_W-1:0] FN_DEL_FRONT = 3'd3;
    localparam logic [FUNC_W-1:0] FN_DEL_BACK  = 3'd4;
    localparam logic [FUNC_W-1:0] FN_DEL_POS   = 3'd5;
    localparam logic [FUNC_W-1:0] FN_READ_ALL  = 3'd6;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_FULL    = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD = 2'd0,
        CELL_INS  = 2'd1,
        CELL_DEL  = 2'd2,
        CELL_ROT  = 2'd3
    } cell_op_t;

    typedef struct packed {
        cell_op_t         op;
        logic [IDX_W-1:0] idx;
        logic [IDX_W-1:0] tail;
    } cell_ctrl_t;

endpackage

@@ rtl/core/ple_cell.sv @@
// One storage cell of the positional list engine shift chain.
// Depends on ple_pkg for the control word and widths.
module ple_cell (
    input  logic                             clk,
    input  ple_pkg::cell_ctrl_t              ctrl,
    input  logic [ple_pkg::IDX_W-1:0]        slot,
    input  logic signed [ple_pkg::DATA_W-1:0] ins_value,
    input  logic signed [ple_pkg::DATA_W-1:0] left,
    input  logic signed [ple_pkg::DATA_W-1:0] right,
    input  logic signed [ple_pkg::DATA_W-1:0] wrap,
    output logic signed [ple_pkg::DATA_W-1:0] q
);

    logic signed [ple_pkg::DATA_W-1:0] data_reg;
    logic signed [ple_pkg::DATA_W-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        case (ctrl.op)
            ple_pkg::CELL_INS:
            begin
                // open a gap at idx: cells above take their left neighbour
                if (slot > ctrl.idx)
                begin
                    data_next = left;
                end
                else if (slot == ctrl.idx)
                begin
                    data_next = ins_value;
                end
            end
            ple_pkg::CELL_DEL:
            begin
                if (slot >= ctrl.idx)
                begin
                    data_next = right;
                end
            end
            ple_pkg::CELL_ROT:
            begin
                // rotate the occupied part left; the tail takes the old head
                if (slot == ctrl.tail)
                begin
                    data_next = wrap;
                end
                else if (slot < ctrl.tail)
                begin
                    data_next = right;
                end
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign q = data_reg;

endmodule

@@ rtl/core/positional_list_engine.sv @@
// Top level of the positional list engine: command decode, count and read-out
// sequencing around a chain of ple_cell storage cells. Depends on ple_pkg, ple_cell.
//
// Usage:
//   Command channel: func, value and position are taken at a rising edge where
//   start is high and busy is low. busy stays high until the block can take
//   the next command.
//   Result channel: each result beat sits on status, element and last for one
//   cycle with done high. The receiver cannot stall; it must take every beat.
// Sequencing:
//   Every command shows its first result beat in the cycle after acceptance.
//   Inserts and deletes shift the whole chain at the accepting edge, then pass
//   through S_DONE. A read-out rotates the chain one cell per cycle and emits
//   the head each cycle; the rotation stops once the list is back in its
//   original order. The cell chain does a single shift/rotate per cycle.
// Reset:
//   rst_n clears the count and the sequencer; cell contents are undefined
//   until written and are never read beyond the count.
module positional_list_engine (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [ple_pkg::FUNC_W-1:0]        func,
    input  logic signed [ple_pkg::DATA_W-1:0] value,
    input  logic [ple_pkg::POS_W-1:0]         position,
    output logic                              done,
    output logic [1:0]                        status,
    output logic signed [ple_pkg::DATA_W-1:0] element,
    output logic                              last
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_DONE = 3'b100
    } state_t;

    state_t                              state_reg, state_next;
    logic [ple_pkg::CNT_W-1:0]           count_reg, count_next;
    logic [ple_pkg::CNT_W-1:0]           rem_reg, rem_next;
    logic [ple_pkg::WIDE_W-1:0]          k_reg, k_next;
    logic                                done_reg, done_next;
    ple_pkg::status_t                    status_reg, status_next;
    logic signed [ple_pkg::DATA_W-1:0]   element_reg, element_next;
    logic                                last_reg, last_next;

    ple_pkg::cell_ctrl_t                 ctrl;
    logic signed [ple_pkg::DATA_W-1:0]   cell_q [ple_pkg::DEPTH];

    logic                                full;
    logic                                empty;
    logic [ple_pkg::CNT_W-1:0]           cnt_m1;
    logic [ple_pkg::POS_W-1:0]           pos_m1;
    logic [ple_pkg::WIDE_W-1:0]          count_w;
    logic [ple_pkg::WIDE_W-1:0]          pos_w;
    logic [ple_pkg::WIDE_W-1:0]          n_w;

    // Cell chain: each cell sees its neighbours and the head for rotation.
    for (genvar i = 0; i < ple_pkg::DEPTH; i++)
    begin : g_cell
        logic signed [ple_pkg::DATA_W-1:0] left_d;
        logic signed [ple_pkg::DATA_W-1:0] right_d;

        if (i == 0)
        begin : g_first
            assign left_d = '0;
        end
        else
        begin : g_left
            assign left_d = cell_q[i-1];
        end

        if (i == ple_pkg::DEPTH - 1)
        begin : g_end
            assign right_d = cell_q[i];
        end
        else
        begin : g_right
            assign right_d = cell_q[i+1];
        end

        ple_cell u_cell (
            .clk       (clk),
            .ctrl      (ctrl),
            .slot      (ple_pkg::IDX_W'(i)),
            .ins_value (value),
            .left      (left_d),
            .right     (right_d),
            .wrap      (cell_q[0]),
            .q         (cell_q[i])
        );
    end

    assign full    = (count_reg == ple_pkg::CNT_W'(ple_pkg::DEPTH));
    assign empty   = (count_reg == '0);
    assign cnt_m1  = count_reg - ple_pkg::CNT_W'(1);
    assign pos_m1  = position - ple_pkg::POS_W'(1);
    assign count_w = ple_pkg::WIDE_W'(count_reg);
    assign pos_w   = ple_pkg::WIDE_W'(position);
    // read-out length: the count, capped at the read-out limit
    assign n_w     = (count_w < ple_pkg::WIDE_W'(ple_pkg::READ_MAX)) ?
                     count_w : ple_pkg::WIDE_W'(ple_pkg::READ_MAX);

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        rem_next     = rem_reg;
        k_next       = k_reg;
        done_next    = 1'b0;
        status_next  = status_reg;
        element_next = element_reg;
        last_next    = last_reg;
        ctrl.op      = ple_pkg::CELL_HOLD;
        ctrl.idx     = '0;
        ctrl.tail    = cnt_m1[ple_pkg::IDX_W-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    // single result beat by default; read-out overrides
                    done_next    = 1'b1;
                    last_next    = 1'b1;
                    element_next = '0;
                    status_next  = ple_pkg::ST_OK;
                    state_next   = S_DONE;
                    case (func)
                        ple_pkg::FN_INS_FRONT, ple_pkg::FN_INS_BACK:
                        begin
                            if (full)
                            begin
                                status_next = ple_pkg::ST_FULL;
                            end
                            else
                            begin
                                ctrl.op    = ple_pkg::CELL_INS;
                                ctrl.idx   = (func == ple_pkg::FN_INS_FRONT) ? '0 :
                                             count_reg[ple_pkg::IDX_W-1:0];
                                count_next = count_reg + ple_pkg::CNT_W'(1);
                            end
                        end
                        ple_pkg::FN_INS_POS:
                        begin
                            if (pos_w == '0 ||
                                pos_w > count_w + ple_pkg::WIDE_W'(1))
                            begin
                                status_next = ple_pkg::ST_INVALID;
                            end
                            else if (full)
                            begin
                                status_next = ple_pkg::ST_FULL;
                            end
                            else
                            begin
                                ctrl.op    = ple_pkg::CELL_INS;
                                ctrl.idx   = pos_m1[ple_pkg::IDX_W-1:0];
                                count_next = count_reg + ple_pkg::CNT_W'(1);
                            end
                        end
                        ple_pkg::FN_DEL_FRONT, ple_pkg::FN_DEL_BACK:
                        begin
                            if (empty)
                            begin
                                status_next = ple_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                ctrl.op      = ple_pkg::CELL_DEL;
                                ctrl.idx     = (func == ple_pkg::FN_DEL_FRONT) ? '0 :
                                               cnt_m1[ple_pkg::IDX_W-1:0];
                                element_next = cell_q[ctrl.idx];
                                count_next   = cnt_m1;
                            end
                        end
                        ple_pkg::FN_DEL_POS:
                        begin
                            if (pos_w == '0)
                            begin
                                status_next = ple_pkg::ST_INVALID;
                            end
                            else if (empty)
                            begin
                                status_next = ple_pkg::ST_EMPTY;
                            end
                            else if (pos_w > count_w)
                            begin
                                status_next = ple_pkg::ST_INVALID;
                            end
                            else
                            begin
                                ctrl.op      = ple_pkg::CELL_DEL;
                                ctrl.idx     = pos_m1[ple_pkg::IDX_W-1:0];
                                element_next = cell_q[ctrl.idx];
                                count_next   = cnt_m1;
                            end
                        end
                        ple_pkg::FN_READ_ALL:
                        begin
                            if (empty)
                            begin
                                status_next = ple_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                // emit the head and rotate in the same edge
                                ctrl.op      = ple_pkg::CELL_ROT;
                                element_next = cell_q[0];
                                last_next    = (n_w == ple_pkg::WIDE_W'(1));
                                k_next       = ple_pkg::WIDE_W'(1);
                                rem_next     = cnt_m1;
                                state_next   = (count_reg == ple_pkg::CNT_W'(1)) ?
                                               S_DONE : S_READ;
                            end
                        end
                        default:
                        begin
                            status_next = ple_pkg::ST_OK;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                // advance the rotation; emit while below the read-out length
                ctrl.op = ple_pkg::CELL_ROT;
                if (k_reg < n_w)
                begin
                    done_next    = 1'b1;
                    status_next  = ple_pkg::ST_OK;
                    element_next = cell_q[0];
                    last_next    = (k_reg + ple_pkg::WIDE_W'(1) == n_w);
                end
                k_next   = k_reg + ple_pkg::WIDE_W'(1);
                rem_next = rem_reg - ple_pkg::CNT_W'(1);
                if (rem_reg == ple_pkg::CNT_W'(1))
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            rem_reg   <= '0;
            k_reg     <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            rem_reg   <= rem_next;
            k_reg     <= k_next;
            done_reg  <= done_next;
        end
    end

    // result payload: no reset, qualified by done
    always_ff @(posedge clk)
    begin
        status_reg  <= status_next;
        element_reg <= element_next;
        last_reg    <= last_next;
    end

    assign busy    = (state_reg != S_IDLE);
    assign done    = done_reg;
    assign status  = status_reg;
    assign element = element_reg;
    assign last    = last_reg;

endmodule

@@ rtl/core/positional_list_engine_chk.sv @@
// Port-level checker for the positional list engine, bound to the top level.
// Depends on ple_pkg for the status codes.
module positional_list_engine_chk (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              start,
    input logic                              busy,
    input logic                              done,
    input logic [1:0]                        status,
    input logic                              last
);

    // every accepted command gives a beat in the next cycle, still busy
    a_accept_beat: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> done && busy)
        else $error("no result beat after command acceptance");

    // beats only appear while a command is in hand
    a_beat_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("result beat while idle");

    // a non-final beat is followed at once by another beat
    a_burst: assert property (@(posedge clk) disable iff (!rst_n)
        done && !last |=> done)
        else $error("gap inside a read-out burst");

    // error outcomes are always single beats
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        done && status != ple_pkg::ST_OK |-> last)
        else $error("error status on a non-final beat");

endmodule

bind positional_list_engine positional_list_engine_chk u_chk (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .status (status),
    .last   (last)
);

@@ tb/sv/ple_shadow_pkg.sv @@
`timescale 1ns / 100ps
// Shadow list for the positional list engine testbench: mirrors the list contents,
// queues the beats each accepted command must produce and checks the beats seen.
// Depends on ple_pkg.
package ple_shadow_pkg;

    import ple_pkg::*;

    typedef struct {
        status_t                  status;
        logic signed [DATA_W-1:0] element;
        logic                     last;
    } list_beat_t;

    class list_shadow;

        logic signed [DATA_W-1:0] cells [DEPTH];
        int unsigned              fill;
        list_beat_t               awaited [$];
        int unsigned              mismatches;

        function new();
            fill       = 0;
            mismatches = 0;
        endfunction

        function int unsigned length();
            return fill;
        endfunction

        function int unsigned outstanding();
            return awaited.size();
        endfunction

        function void queue_beat(status_t st, logic signed [DATA_W-1:0] elem, logic lst);
            list_beat_t b;
            b.status  = st;
            b.element = elem;
            b.last    = lst;
            awaited.push_back(b);
        endfunction

        function void insert_at(int unsigned idx, logic signed [DATA_W-1:0] v);
            for (int unsigned i = fill; i > idx; i--)
                cells[i] = cells[i - 1];
            cells[idx] = v;
            fill++;
        endfunction

        function logic signed [DATA_W-1:0] remove_at(int unsigned idx);
            logic signed [DATA_W-1:0] taken;
            taken = cells[idx];
            for (int unsigned i = idx; i + 1 < fill; i++)
                cells[i] = cells[i + 1];
            fill--;
            return taken;
        endfunction

        // Apply one accepted command to the shadow list and queue its beats.
        function void note_command(logic [FUNC_W-1:0] op, logic signed [DATA_W-1:0] v,
                                   logic [POS_W-1:0] pos);
            status_t                  st;
            logic signed [DATA_W-1:0] taken;
            int unsigned              p;
            int unsigned              n;
            st    = ST_OK;
            taken = '0;
            p     = 32'(pos);
            case (op)
                FN_INS_FRONT, FN_INS_BACK:
                    if (fill >= DEPTH)
                        st = ST_FULL;
                    else
                        insert_at((op == FN_INS_FRONT) ? 0 : fill, v);
                FN_INS_POS:
                    // the position check wins over the full check
                    if (p == 0 || p > fill + 1)
                        st = ST_INVALID;
                    else if (fill >= DEPTH)
                        st = ST_FULL;
                    else
                        insert_at(p - 1, v);
                FN_DEL_FRONT, FN_DEL_BACK:
                    if (fill == 0)
                        st = ST_EMPTY;
                    else
                        taken = remove_at((op == FN_DEL_FRONT) ? 0 : fill - 1);
                FN_DEL_POS:
                    if (p == 0)
                        st = ST_INVALID;
                    else if (fill == 0)
                        st = ST_EMPTY;
                    else if (p > fill)
                        st = ST_INVALID;
                    else
                        taken = remove_at(p - 1);
                FN_READ_ALL:
                begin
                    n = (fill < READ_MAX) ? fill : READ_MAX;
                    if (n == 0)
                        queue_beat(ST_EMPTY, '0, 1'b1);
                    for (int unsigned i = 0; i < n; i++)
                        queue_beat(ST_OK, cells[i], i + 1 == n);
                    return;
                end
                default:
                    ;
            endcase
            queue_beat(st, taken, 1'b1);
        endfunction

        // Compare one result beat with the oldest beat still awaited.
        function void check_beat(logic [1:0] st, logic signed [DATA_W-1:0] elem, logic lst);
            list_beat_t want;
            if (awaited.size() == 0)
            begin
                $display("%0t: unexpected beat: status %0d element %0d last %0b",
                         $time, st, elem, lst);
                mismatches++;
                return;
            end
            want = awaited.pop_front();
            if (st !== want.status)
            begin
                $display("%0t: status mismatch: expected %0d, actual %0d",
                         $time, want.status, st);
                mismatches++;
            end
            if (elem !== want.element)
            begin
                $display("%0t: element mismatch: expected %0d, actual %0d",
                         $time, want.element, elem);
                mismatches++;
            end
            if (lst !== want.last)
            begin
                $display("%0t: last mismatch: expected %0b, actual %0b",
                         $time, want.last, lst);
                mismatches++;
            end
        endfunction

    endclass

endpackage

@@ tb/sv/tb_positional_list_engine.sv @@
`timescale 1ns / 100ps
// Top-level testbench for the positional list engine: drives directed and random
// commands in bursts and checks every result beat against a shadow list.
// Depends on ple_pkg, ple_shadow_pkg and the positional_list_engine RTL.
module tb_positional_list_engine;

    import ple_pkg::*;
    import ple_shadow_pkg::*;

    // func code 7 has no operation behind it; the block must answer ok and move on
    localparam logic [FUNC_W-1:0] FN_UNUSED = 3'd7;

    localparam int HALF_PERIOD     = 6;
    localparam int RESET_CYCLES    = 8;
    localparam int RANDOM_COMMANDS = 300;
    // longest read-out is READ_MAX beats; allow some slack after it
    localparam int DRAIN_CYCLES    = READ_MAX + 8;
    // worst case is roughly 330 commands, each at most a full read-out, plus gaps;
    // take it many times over
    localparam int TIMEOUT_NS      = 5_000_000;

    logic                     clk      = 1'b0;
    logic                     rst_n    = 1'b0;
    logic                     start    = 1'b0;
    logic [FUNC_W-1:0]        func     = '0;
    logic signed [DATA_W-1:0] value    = '0;
    logic [POS_W-1:0]         position = '0;
    logic                     busy;
    logic                     done;
    logic [1:0]               status;
    logic signed [DATA_W-1:0] element;
    logic                     last;

    list_shadow  tracker;
    // commands left in the current burst before the sender takes a break
    int unsigned burst_left = 0;

    always #(HALF_PERIOD) clk = ~clk;

    positional_list_engine u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .func     (func),
        .value    (value),
        .position (position),
        .done     (done),
        .status   (status),
        .element  (element),
        .last     (last)
    );

    // The receiver cannot stall, so every edge with done high carries a beat.
    always @(posedge clk)
    begin
        if (rst_n && done)
            tracker.check_beat(status, element, last);
    end

    // Present one command, hold it until the block takes it, then note it in the
    // shadow list. Drop start for a random gap once the burst runs out.
    task automatic send_command(input logic [FUNC_W-1:0] f,
                                input logic signed [DATA_W-1:0] v,
                                input logic [POS_W-1:0] p);
        start    <= 1'b1;
        func     <= f;
        value    <= v;
        position <= p;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        tracker.note_command(f, v, p);
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6))
                @(posedge clk);
            // mostly short bursts, now and then a long stretch with no gaps
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 8);
        end
    endtask

    // Hold the sender off until every awaited beat has arrived.
    task automatic wait_for_results();
        start <= 1'b0;
        @(posedge clk);
        while (tracker.outstanding() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        logic [FUNC_W-1:0]        f;
        logic signed [DATA_W-1:0] v;
        logic [POS_W-1:0]         p;
        int unsigned              held;
        int unsigned              limit;
        int unsigned              roll;
        bit                       growing;

        tracker = new();
        growing = 1'b1;

        repeat (RESET_CYCLES)
            @(posedge clk);
        rst_n <= 1'b1;

        // Directed part: walk the empty-list, position and extreme-value corners.
        send_command(FN_READ_ALL,  '0, '0);               // read-out of an empty list
        send_command(FN_DEL_FRONT, '0, '0);               // delete from empty
        send_command(FN_DEL_BACK,  '0, '0);
        send_command(FN_DEL_POS,   '0, 6'd0);             // position 0 beats empty
        send_command(FN_DEL_POS,   '0, 6'd1);             // empty list
        send_command(FN_INS_POS,   32'sd5, 6'd0);         // invalid position
        send_command(FN_INS_POS,   32'sd5, 6'd2);         // past count plus one
        send_command(FN_INS_FRONT, 32'sh7FFF_FFFF, 6'd63);
        send_command(FN_INS_BACK,  32'sh8000_0000, 6'd0);
        send_command(FN_INS_POS,   -32'sd1, 6'd1);
        send_command(FN_INS_POS,   32'sd0, 6'd4);         // append via position
        send_command(FN_INS_POS,   32'sd9, 6'd63);        // invalid position
        send_command(FN_UNUSED,    32'sh5A5A_5A5A, 6'd63);
        send_command(FN_READ_ALL,  '0, '0);
        send_command(FN_DEL_POS,   '0, 6'd63);            // past the count
        send_command(FN_DEL_POS,   '0, 6'd5);
        send_command(FN_DEL_POS,   '0, 6'd2);
        send_command(FN_DEL_FRONT, '0, '0);
        send_command(FN_DEL_BACK,  '0, '0);
        send_command(FN_DEL_POS,   '0, 6'd1);             // empties the list
        send_command(FN_READ_ALL,  '0, '0);

        // Random part: swing the list between empty and full so both ends,
        // including inserts into a full list, get plenty of traffic.
        for (int n = 0; n < RANDOM_COMMANDS; n++)
        begin
            // hold the sender off once until the block has gone quiet
            if (n == RANDOM_COMMANDS / 2)
                wait_for_results();

            held = tracker.length();
            if (growing && held == DEPTH && $urandom_range(0, 3) == 0)
                growing = 1'b0;
            else if (!growing && held == 0 && $urandom_range(0, 3) == 0)
                growing = 1'b1;

            roll = $urandom_range(0, 99);
            if ((roll < 75) == growing)
            begin
                case ($urandom_range(0, 2))
                    0:       f = FN_INS_FRONT;
                    1:       f = FN_INS_BACK;
                    default: f = FN_INS_POS;
                endcase
            end
            else
            begin
                case ($urandom_range(0, 2))
                    0:       f = FN_DEL_FRONT;
                    1:       f = FN_DEL_BACK;
                    default: f = FN_DEL_POS;
                endcase
            end
            if (roll >= 95)
                f = FN_UNUSED;
            else if (roll >= 87)
                f = FN_READ_ALL;

            // values: mostly fully random, sometimes the signed extremes
            case ($urandom_range(0, 15))
                0:       v = 32'sh8000_0000;
                1:       v = 32'sh7FFF_FFFF;
                2:       v = -32'sd1;
                3:       v = '0;
                default: v = $urandom();
            endcase

            // positions: mostly legal, some just off either end, some anywhere
            if (f == FN_INS_POS || f == FN_DEL_POS)
            begin
                limit = (f == FN_INS_POS) ? held + 1 : held;
                roll  = $urandom_range(0, 99);
                if (roll < 85 && limit > 0)
                    p = POS_W'($urandom_range(1, limit));
                else if (roll < 95)
                    p = POS_W'(($urandom_range(0, 1) == 0 || limit >= 63) ? 0 : limit + 1);
                else
                    p = POS_W'($urandom_range(0, 63));
            end
            else
                p = POS_W'($urandom_range(0, 63));

            send_command(f, v, p);
        end

        wait_for_results();
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        if (tracker.mismatches == 0 && tracker.outstanding() == 0)
            $display("[positional_list_engine] OK");
        else
            $display("[positional_list_engine] ERROR");
        $finish;
    end

    // Guard against a hung handshake or lost beats.
    initial
    begin
        #(TIMEOUT_NS);
        $display("[positional_list_engine] ERROR");
        $finish;
    end

endmodule
